[sv/plti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned CNT_W          = 7;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] point_position;
    logic signed [DATA_W-1:0] point_value;
    logic signed [DATA_W-1:0] query_position;
  } plti_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     in_range;
    logic                     exact_hit;
  } plti_out_t;

  // request to the multiply/divide unit: quo = (mag * dq) / dx
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] dq;
    logic [DATA_W-1:0] dx;
  } plti_md_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } plti_md_rsp_t;

endpackage

`default_nettype wire

[sv/plti_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module plti_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/plti_muldiv.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiply (32 steps) then restoring divide (32 steps), one shared
// 33-bit adder. Needs dq < dx so the quotient fits in 32 bits.
module plti_muldiv (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire plti_pkg::plti_md_req_t req_i,
  output plti_pkg::plti_md_rsp_t      rsp_o
);

  localparam int unsigned W = plti_pkg::DATA_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]     phase_q, phase_d;
  logic [4:0]     cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [2*W-1:0] acc_q, acc_d;
  logic [W-1:0]   mag_q, mag_d;
  logic [W-1:0]   dx_q, dx_d;

  // shared adder
  logic [W:0]   add_a, add_b;
  logic         add_sub;
  logic [W+1:0] add_r;

  always_comb begin
    add_a   = {1'b0, acc_q[2*W-1:W]};
    add_b   = '0;
    add_sub = 1'b0;
    if (phase_q == PH_DIV) begin
      add_a   = {acc_q[2*W-1:W], acc_q[W-1]};
      add_b   = {1'b0, dx_q};
      add_sub = 1'b1;
    end else if (acc_q[0]) begin
      add_b   = {1'b0, mag_q};
    end
    add_r = {1'b0, add_a} + {1'b0, add_b ^ {(W+1){add_sub}}} + {{(W+1){1'b0}}, add_sub};
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    mag_d   = mag_q;
    dx_d    = dx_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          acc_d   = {{W{1'b0}}, req_i.dq};
          mag_d   = req_i.mag;
          dx_d    = req_i.dx;
          cnt_d   = '0;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        acc_d = {add_r[W:0], acc_q[W-1:1]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        // carry out set means no borrow: quotient bit is 1
        if (add_r[W+1]) begin
          acc_d = {add_r[W-1:0], acc_q[W-2:0], 1'b1};
        end else begin
          acc_d = {add_a[W-1:0], acc_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mag_q <= mag_d;
    dx_q  <= dx_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = acc_q[W-1:0];

endmodule

`default_nettype wire

[sv/piecewise_linear_table_interp_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Write word: no result; the next word may follow at once.
// Query word: each scanned entry takes a RAM read and a compare; then an
//   exact hit or a miss goes to hand-off, or an interpolation runs setup,
//   the 32-step multiply, the 32-step divide, done and hand-off. The input
//   stalls for the whole query and while a finished result waits behind a
//   stalled output word.
// Reset (async, active low) clears point_count, the sequencer and out valid;
//   the point table is not cleared.
module piecewise_linear_table_interp_core #(
  parameter int unsigned MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire plti_pkg::plti_in_t       in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output plti_pkg::plti_out_t           out_data_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [plti_pkg::CNT_W-1:0] cfg_data_i
);

  localparam int unsigned W  = plti_pkg::DATA_W;
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;  // issue table read
  localparam logic [2:0] S_CMP   = 3'd2;  // test exact hit / bracket
  localparam logic [2:0] S_SETUP = 3'd3;  // form deltas, start multiply/divide unit
  localparam logic [2:0] S_MD    = 3'd4;  // wait for multiply/divide
  localparam logic [2:0] S_FIN   = 3'd5;  // hand result to output register

  logic [2:0]   state_q, state_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] n_q, n_d;
  logic [plti_pkg::CNT_W-1:0] count_q;

  logic signed [W-1:0] qpos_q, qpos_d;
  logic signed [W-1:0] prev_pos_q, prev_pos_d;
  logic signed [W-1:0] prev_val_q, prev_val_d;
  logic signed [W-1:0] res_q, res_d;
  logic                ok_q, ok_d, hit_q, hit_d, neg_q, neg_d;

  logic                out_valid_q, out_valid_d;
  plti_pkg::plti_out_t out_q, out_d;

  logic in_acc, out_load;
  logic [CW-1:0] n_clip;

  // table RAM: {position, value}
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [2*W-1:0] ram_rdata;
  logic signed [W-1:0] rd_pos, rd_val;

  plti_pkg::plti_md_req_t md_req;
  plti_pkg::plti_md_rsp_t md_rsp;

  logic signed [W:0] dv, dq, dx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  // writes beyond the table depth are dropped
  assign ram_we    = in_acc && (in_data_i.command == plti_pkg::CMD_WRITE) &&
                     (32'(in_data_i.point_index) < 32'(MAX_POINTS));
  assign ram_waddr = AW'(in_data_i.point_index);
  assign ram_re    = (state_q == S_RD);

  plti_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_data_i.point_position, in_data_i.point_value}),
    .re_i    (ram_re),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_pos = ram_rdata[2*W-1:W];
  assign rd_val = ram_rdata[W-1:0];

  // point_count above the depth acts as the depth
  assign n_clip = (32'(count_q) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_q);

  // deltas for the bracketing pair (prev, current read)
  assign dv = {rd_val[W-1], rd_val} - {prev_val_q[W-1], prev_val_q};
  assign dq = {qpos_q[W-1], qpos_q} - {prev_pos_q[W-1], prev_pos_q};
  assign dx = {rd_pos[W-1], rd_pos} - {prev_pos_q[W-1], prev_pos_q};

  always_comb begin
    md_req.start = (state_q == S_SETUP);
    md_req.mag   = dv[W] ? W'(-dv) : dv[W-1:0];
    md_req.dq    = dq[W-1:0];
    md_req.dx    = dx[W-1:0];
  end

  plti_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    n_d        = n_q;
    qpos_d     = qpos_q;
    prev_pos_d = prev_pos_q;
    prev_val_d = prev_val_q;
    res_d      = res_q;
    ok_d       = ok_q;
    hit_d      = hit_q;
    neg_d      = neg_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.command == plti_pkg::CMD_QUERY)) begin
          qpos_d = in_data_i.query_position;
          n_d    = n_clip;
          i_d    = '0;
          res_d  = '0;
          ok_d   = 1'b0;
          hit_d  = 1'b0;
          state_d = (n_clip == '0) ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (qpos_q == rd_pos) begin
          res_d   = rd_val;
          ok_d    = 1'b1;
          hit_d   = 1'b1;
          state_d = S_FIN;
        end else if ((i_q != '0) && (qpos_q > prev_pos_q) && (qpos_q < rd_pos)) begin
          ok_d    = 1'b1;
          state_d = S_SETUP;
        end else begin
          prev_pos_d = rd_pos;
          prev_val_d = rd_val;
          i_d        = i_q + CW'(1);
          state_d    = (i_q + CW'(1) == n_q) ? S_FIN : S_RD;
        end
      end
      S_SETUP: begin
        neg_d   = dv[W];
        state_d = S_MD;
      end
      S_MD: begin
        if (md_rsp.done) begin
          res_d   = neg_q ? (prev_val_q - md_rsp.quo) : (prev_val_q + md_rsp.quo);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d        = 1'b1;
      out_d.result_value = res_q;
      out_d.in_range     = ok_q;
      out_d.exact_hit    = hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      n_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qpos_q     <= qpos_d;
    prev_pos_q <= prev_pos_d;
    prev_val_q <= prev_val_d;
    res_q      <= res_d;
    ok_q       <= ok_d;
    hit_q      <= hit_d;
    neg_q      <= neg_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/plti_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module plti_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire plti_pkg::plti_in_t         in_data_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire plti_pkg::plti_out_t        out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      (out_data_o.result_value == '0) && !out_data_o.exact_hit)
    else $error("out-of-range result not zero");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.exact_hit |-> out_data_o.in_range)
    else $error("exact hit without in_range");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.command == plti_pkg::CMD_QUERY) |=> in_stall_o)
    else $error("input not stalled after query");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.command == plti_pkg::CMD_WRITE) |=> !in_stall_o)
    else $error("input stalled after table write");

endmodule

bind piecewise_linear_table_interp_core plti_checker u_plti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[sim/plti_lookup_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the interpolation table core, keeps its own
// copy of the point table and count, and predicts one result word per query.
module plti_lookup_checker #(
  parameter int unsigned MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire plti_pkg::plti_in_t         in_data_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire plti_pkg::plti_out_t        out_data_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [plti_pkg::CNT_W-1:0] cfg_data_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);

  logic signed [31:0]         pos_tab [MAX_POINTS];
  logic signed [31:0]         val_tab [MAX_POINTS];
  logic [plti_pkg::CNT_W-1:0] point_count;
  plti_pkg::plti_out_t        lookup_results_q [$];

  initial begin
    fail_cnt_o  = 0;
    pending_o   = 0;
    point_count = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      pos_tab[i] = '0;
      val_tab[i] = '0;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_cnt_o < 40)
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    fail_cnt_o++;
  endtask

  // First entry that is an exact hit or closes a bracket with its
  // predecessor decides; everything else is the no-match word.
  function automatic plti_pkg::plti_out_t interp_lookup(input logic signed [31:0] qpos);
    plti_pkg::plti_out_t r;
    int                  n;
    longint              q, xl, xu, vl, vu, dv, term, sum;
    logic [63:0]         mag, dq, dx, quo;
    r = '0;
    q = qpos;
    n = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
    for (int i = 0; i < n; i++) begin
      xu = pos_tab[i];
      if (q == xu) begin
        r.result_value = val_tab[i];
        r.in_range     = 1'b1;
        r.exact_hit    = 1'b1;
        return r;
      end
      if (i > 0) begin
        xl = pos_tab[i-1];
        if (q > xl && q < xu) begin
          vl   = val_tab[i-1];
          vu   = val_tab[i];
          dv   = vu - vl;
          mag  = (dv < 0) ? 64'(-dv) : 64'(dv);
          dq   = 64'(q - xl);
          dx   = 64'(xu - xl);
          quo  = (mag * dq) / dx;        // truncates toward zero on magnitude
          term = (dv < 0) ? -longint'(quo) : longint'(quo);
          sum  = vl + term;
          r.result_value = sum[31:0];
          r.in_range     = 1'b1;
          return r;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    plti_pkg::plti_out_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i)
        point_count = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (lookup_results_q.size() == 0) begin
          report_mismatch("result word with no query pending", got.result_value, '0);
        end else begin
          want = lookup_results_q.pop_front();
          if (got.result_value !== want.result_value)
            report_mismatch("result_value", got.result_value, want.result_value);
          if (got.in_range !== want.in_range)
            report_mismatch("in_range", 32'(got.in_range), 32'(want.in_range));
          if (got.exact_hit !== want.exact_hit)
            report_mismatch("exact_hit", 32'(got.exact_hit), 32'(want.exact_hit));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.command == plti_pkg::CMD_WRITE) begin
          if (in_data_i.point_index < MAX_POINTS) begin
            pos_tab[in_data_i.point_index] = in_data_i.point_position;
            val_tab[in_data_i.point_index] = in_data_i.point_value;
          end
        end else begin
          lookup_results_q.insert(lookup_results_q.size(),
                                  interp_lookup(in_data_i.query_position));
        end
      end
      pending_o = lookup_results_q.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the interpolation table core; all prediction and
// comparison lives in the checker beside the block.
module testbench;

  localparam int     RANDOM_WORDS  = 850;
  localparam int     HOLD_AT       = 200;   // word count that triggers the long hold
  localparam int     HOLD_CYCLES   = 400;
  localparam int     CALM_FROM     = 450;   // stretch with no idling on either side
  localparam int     CALM_TO       = 580;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     TAIL_CYCLES   = 250;   // longer than the worst-case query
  localparam longint POS_MIN       = -longint'(32'h8000_0000);

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  plti_pkg::plti_in_t             in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  plti_pkg::plti_out_t            out_data_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [plti_pkg::CNT_W-1:0]     cfg_data_i;
  int                             fail_cnt;
  int                             pending;

  int                   word_cnt;
  bit                   calm;
  logic signed [31:0]   sh_pos [64];   // positions as sent, for picking queries
  bit                   sh_written [64];

  piecewise_linear_table_interp_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  plti_lookup_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, none during the calm stretch, and one long
  // hold so the block backs up and stalls its input.
  initial begin : rx
    bit held;
    held = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && word_cnt >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 27);
    end
  end

  function automatic longint rand_below(input longint span);
    logic [63:0] r;
    if (span <= 0) return 0;
    r = {$urandom, $urandom};
    return longint'(r % 64'(span));
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    return $urandom;
  endfunction

  // Mostly hits, brackets and near misses on the points in use.
  function automatic logic [31:0] pick_query(input int eff);
    int     sel, i;
    longint lo, hi;
    if (eff == 0) return $urandom;
    sel = $urandom_range(0, 99);
    i   = $urandom_range(0, eff - 1);
    if (sel < 30) return sh_pos[i];
    if (sel < 65 && eff > 1) begin
      i  = $urandom_range(1, eff - 1);
      lo = sh_pos[i-1];
      hi = sh_pos[i];
      if (hi - lo > 1) return 32'(lo + 1 + rand_below(hi - lo - 1));
      return sh_pos[i-1];
    end
    if (sel < 75) return sh_pos[i] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
    if (sel < 85) begin
      if (sel[0]) return sh_pos[0] - $urandom_range(1, 4096);
      return sh_pos[eff-1] + $urandom_range(1, 4096);
    end
    if (sel < 90) return sel[0] ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom;
  endfunction

  // Called and returns at a falling edge; the word is held until taken.
  task automatic push_word(input plti_pkg::plti_in_t w);
    if (!calm)
      while ($urandom_range(0, 99) < 27) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    word_cnt++;
    calm = (word_cnt >= CALM_FROM && word_cnt < CALM_TO);
    @(negedge clk_i);
  endtask

  task automatic put_point(input int idx, input logic [31:0] p, input logic [31:0] v);
    plti_pkg::plti_in_t w;
    w.command        = plti_pkg::CMD_WRITE;
    w.point_index    = idx[plti_pkg::IDX_W-1:0];
    w.point_position = p;
    w.point_value    = v;
    w.query_position = $urandom;          // don't care on a write
    sh_pos[idx]      = p;
    sh_written[idx]  = 1'b1;
    push_word(w);
  endtask

  task automatic ask(input logic [31:0] q);
    plti_pkg::plti_in_t w;
    w.command        = plti_pkg::CMD_QUERY;
    w.point_index    = $urandom;
    w.point_position = $urandom;
    w.point_value    = $urandom;
    w.query_position = q;
    push_word(w);
  endtask

  // Drain all pending queries, then give trailing writes time to land.
  task automatic settle(input int cycles);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic set_count(input int c);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c[plti_pkg::CNT_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Fresh table for entries 0..eff-1: ascending with varied spacing, a
  // dense one for unit brackets, one with repeats, or plain noise.
  task automatic build_table(input int eff);
    int          mode;
    longint      lim, step_max, cur;
    logic [31:0] p;
    mode     = $urandom_range(0, 7);
    lim      = 64'd4294967295 / (eff + 1);
    step_max = (mode == 0) ? 3 : (mode == 1) ? (lim >> $urandom_range(4, 24)) : lim;
    if (step_max < 1) step_max = 1;
    cur = ($urandom_range(0, 3) == 0) ? POS_MIN : POS_MIN + rand_below(lim);
    for (int i = 0; i < eff; i++) begin
      if (mode == 7) begin
        p = $urandom;
      end else begin
        p   = cur[31:0];
        cur = cur + ((mode == 6) ? rand_below(3) : 1 + rand_below(step_max));
      end
      put_point(i, p, pick_value());
    end
  endtask

  initial begin : stim
    int          start, phase, cnt, eff, idx;
    bit          need;
    longint      gap;
    logic [31:0] p;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    word_cnt    = 0;
    calm        = 1'b0;
    for (int i = 0; i < 64; i++) begin
      sh_pos[i]     = '0;
      sh_written[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table
    set_count(0);
    ask(32'h0000_0000);
    ask(32'h8000_0000);

    // four points spanning the whole range, extreme values
    put_point(0, 32'h8000_0000, 32'h7fff_ffff);
    put_point(1, 32'hffff_ffff, 32'h8000_0000);
    put_point(2, 32'h0001_0000, 32'h0000_0000);
    put_point(3, 32'h7fff_ffff, 32'h7fff_ffff);
    put_point(63, $urandom, $urandom);
    settle(SETTLE_CYCLES);
    set_count(4);
    ask(32'h8000_0000);                    // hit on first entry
    ask(32'h8000_0001);                    // widest bracket, steepest fall
    ask(32'hffff_fffe);
    ask(32'hffff_ffff);                    // hit
    ask(32'h0000_0000);                    // bracket between entries 1 and 2
    ask(32'h0001_0000);
    ask(32'h7fff_fffe);
    ask(32'h7fff_ffff);                    // hit on last entry

    // entry 2 out of order: only neighbor pairs count
    put_point(2, 32'h8000_0005, 32'h0000_1234);
    ask(32'h0002_0000);

    // nothing brackets a position above the last point in use
    settle(SETTLE_CYCLES);
    set_count(2);
    ask(32'h0000_0005);

    start = word_cnt;
    phase = 0;
    while (word_cnt - start < RANDOM_WORDS) begin
      settle(SETTLE_CYCLES);
      case (phase % 8)
        0:       cnt = 0;
        1:       cnt = 64;
        2:       cnt = 127;
        3:       cnt = 1;
        4:       cnt = 2;
        5:       cnt = $urandom_range(65, 126);
        6:       cnt = $urandom_range(0, 127);
        default: cnt = $urandom_range(3, 12);
      endcase
      eff = (cnt > 64) ? 64 : cnt;
      set_count(cnt);

      // every entry a query may scan must have been written
      need = 1'b0;
      for (int i = 0; i < eff; i++)
        if (!sh_written[i]) need = 1'b1;
      if (eff > 0 && (need || $urandom_range(0, 2) == 0))
        build_table(eff);

      repeat ($urandom_range(8, 24)) begin
        if ($urandom_range(0, 99) < 25) begin
          idx = ($urandom_range(0, 1) && eff > 0) ? $urandom_range(0, eff - 1)
                                                  : $urandom_range(0, 63);
          p   = $urandom;
          // usually keep the table ordered around the rewritten entry
          if ($urandom_range(0, 2) != 0 && idx > 0 && idx < 63 &&
              sh_written[idx-1] && sh_written[idx+1]) begin
            gap = longint'(sh_pos[idx+1]) - longint'(sh_pos[idx-1]);
            if (gap > 1) p = 32'(longint'(sh_pos[idx-1]) + 1 + rand_below(gap - 1));
          end
          put_point(idx, p, pick_value());
        end else begin
          ask(pick_query(eff));
        end
      end
      phase++;
    end

    settle(TAIL_CYCLES);
    if (fail_cnt == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
